// ----- hw/rtl/sgh_pkg.sv -----
package sgh_pkg;

    localparam int unsigned VAL_W       = 12;
    localparam int unsigned TICK_W      = 32;
    localparam int unsigned GEST_W      = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [GEST_W-1:0] t_gesture;

    localparam t_gesture GEST_NONE      = 2'd0;
    localparam t_gesture GEST_CALIBRATE = 2'd1;
    localparam t_gesture GEST_ARM       = 2'd2;
    localparam t_gesture GEST_DISARM    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 2'd2;

    localparam logic [VAL_W-1:0]  LOW_THRESHOLD_RST  = 12'd1100;
    localparam logic [VAL_W-1:0]  HIGH_THRESHOLD_RST = 12'd1900;
    localparam logic [TICK_W-1:0] HOLD_TICKS_RST     = 32'd1000;

    typedef struct packed {
        logic [VAL_W-1:0] low_threshold;
        logic [VAL_W-1:0] high_threshold;
    } t_thresholds;

    typedef struct packed {
        t_gesture          seen;
        logic [TICK_W-1:0] now_tick;
    } t_qitem;

    function automatic t_gesture classify(input logic [VAL_W-1:0] thr,
                                          input logic [VAL_W-1:0] yaw,
                                          input logic [VAL_W-1:0] pitch,
                                          input t_thresholds    th);
        logic thr_low;
        logic yaw_right;
        logic yaw_left;
        logic pitch_up;
        t_gesture g;
        thr_low   = thr < th.low_threshold;
        yaw_right = yaw > th.high_threshold;
        yaw_left  = yaw < th.low_threshold;
        pitch_up  = pitch > th.high_threshold;
        // priority order: calibrate, arm, disarm
        if (thr_low && yaw_left && pitch_up) begin
            g = GEST_CALIBRATE;
        end else if (thr_low && yaw_right) begin
            g = GEST_ARM;
        end else if (thr_low && yaw_left) begin
            g = GEST_DISARM;
        end else begin
            g = GEST_NONE;
        end
        return g;
    endfunction

endpackage

// ----- hw/rtl/sgh_if.sv -----
interface sgh_in_if;
    import sgh_pkg::*;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  throttle_value;
    logic [VAL_W-1:0]  yaw_value;
    logic [VAL_W-1:0]  pitch_value;
    logic [TICK_W-1:0] now_tick;

    modport source (output valid, output throttle_value, output yaw_value,
                    output pitch_value, output now_tick, input ready);
    modport sink   (input valid, input throttle_value, input yaw_value,
                    input pitch_value, input now_tick, output ready);
endinterface

interface sgh_out_if;
    import sgh_pkg::*;
    logic     valid;
    logic     ready;
    t_gesture gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

// ----- hw/rtl/stick_gesture_hold_detector_top.sv -----
// stick gesture hold detector
//
// i_in carries one stick item: throttle, yaw and pitch pulse widths and the
// current tick. o_out returns exactly one gesture code per input item, in
// order: none, or calibrate / arm / disarm on the item where a held gesture
// first exceeds the hold time.
// the config port writes low_threshold, high_threshold and hold_ticks by
// index on any edge with i_cfg_we high; unknown indexes are dropped.
// throughput is one item per cycle while the receiver keeps o_out.ready high.
// an item is classified and written into the queue at its accept edge; the
// back end pops it when the output register is empty or being taken and
// registers its gesture there, raising o_out.valid. the back end holds the
// single state register set and the 32-bit elapsed-time compare.
// a two-entry queue sits between classify and tracking; when the receiver
// stalls the output register holds its item, the queue fills, and i_in.ready
// drops once it is full.
// synchronous reset restores the default thresholds and hold time, clears
// tracking and empties the queue and output register.
module stick_gesture_hold_detector_top #(
    parameter int unsigned QUEUE_DEPTH = sgh_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sgh_in_if.sink                          i_in,
    sgh_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [sgh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sgh_pkg::*;

    t_thresholds       r_th;
    logic [TICK_W-1:0] r_hold_ticks;
    logic              push_valid;
    logic              push_ready;
    t_qitem            push_item;
    logic              pop_valid;
    logic              pop_ready;
    t_qitem            pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th.low_threshold  <= LOW_THRESHOLD_RST;
            r_th.high_threshold <= HIGH_THRESHOLD_RST;
            r_hold_ticks        <= HOLD_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_THRESHOLD:  r_th.low_threshold  <= i_cfg_data[VAL_W-1:0];
                CFG_HIGH_THRESHOLD: r_th.high_threshold <= i_cfg_data[VAL_W-1:0];
                CFG_HOLD_TICKS:     r_hold_ticks        <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    sgh_front u_front (
        .i_in         (i_in),
        .i_th         (r_th),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    sgh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    sgh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold_ticks (r_hold_ticks),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_item   (pop_item),
        .o_out        (o_out)
    );

endmodule

// ----- hw/rtl/sgh_front.sv -----
module sgh_front (
    sgh_in_if.sink         i_in,
    input  sgh_pkg::t_thresholds i_th,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output sgh_pkg::t_qitem o_push_item
);
    import sgh_pkg::*;

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    always_comb begin
        o_push_item.seen     = classify(i_in.throttle_value, i_in.yaw_value,
                                        i_in.pitch_value, i_th);
        o_push_item.now_tick = i_in.now_tick;
    end

endmodule

// ----- hw/rtl/sgh_queue.sv -----
module sgh_queue #(
    parameter int unsigned DEPTH = sgh_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  sgh_pkg::t_qitem i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output sgh_pkg::t_qitem o_pop_item
);
    import sgh_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_qitem           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push_fire;
    logic             pop_fire;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push_fire    = i_push_valid && o_push_ready;
    assign pop_fire     = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_fire) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_fire) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({push_fire, pop_fire})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- hw/rtl/sgh_back.sv -----
module sgh_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sgh_pkg::TICK_W-1:0]   i_hold_ticks,
    input  logic                         i_pop_valid,
    output logic                         o_pop_ready,
    input  sgh_pkg::t_qitem              i_pop_item,
    sgh_out_if.source                    o_out
);
    import sgh_pkg::*;

    logic              r_tracking,   n_tracking;
    t_gesture          r_candidate,  n_candidate;
    logic [TICK_W-1:0] r_start_tick, n_start_tick;
    logic              r_out_valid,  n_out_valid;
    t_gesture          r_gesture,    n_gesture;
    logic [TICK_W-1:0] elapsed;
    logic              pop_fire;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop_fire    = i_pop_valid && o_pop_ready;
    // elapsed time wraps modulo 2^32
    assign elapsed     = i_pop_item.now_tick - r_start_tick;

    always_comb begin
        n_tracking   = r_tracking;
        n_candidate  = r_candidate;
        n_start_tick = r_start_tick;
        n_gesture    = r_gesture;
        n_out_valid  = r_out_valid && !o_out.ready;
        if (pop_fire) begin
            n_out_valid = 1'b1;
            n_gesture   = GEST_NONE;
            if (i_pop_item.seen != GEST_NONE) begin
                if (!r_tracking || r_candidate != i_pop_item.seen) begin
                    n_start_tick = i_pop_item.now_tick;
                    n_tracking   = 1'b1;
                    n_candidate  = i_pop_item.seen;
                end else if (elapsed > i_hold_ticks) begin
                    // report once, keep candidate so a continued hold retimes
                    n_tracking = 1'b0;
                    n_gesture  = r_candidate;
                end
            end else begin
                n_tracking  = 1'b0;
                n_candidate = GEST_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking   <= 1'b0;
            r_candidate  <= GEST_NONE;
            r_start_tick <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_tracking   <= n_tracking;
            r_candidate  <= n_candidate;
            r_start_tick <= n_start_tick;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gesture <= n_gesture;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.gesture = r_gesture;

endmodule

// ----- hw/rtl/sgh_checker.sv -----
module sgh_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input sgh_pkg::t_gesture      i_out_gesture
);
    import sgh_pkg::*;

    // output register comes up empty after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // queue can only fill while the output side is stalled
    a_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input blocked with empty output register");

    // an accepted item into an idle block reaches the output through the queue and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) ##1 i_rst_n |=> i_out_valid)
        else $error("accepted item did not reach the output");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_gesture)))
        else $error("stalled output item changed");

endmodule

bind stick_gesture_hold_detector_top sgh_checker u_sgh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_gesture (o_out.gesture)
);
